FILE: rtl/core/rdxp_pkg.sv
// Package for the radix partitioner: sizes, request/result codes and the
// payload, job and per-partition state types shared by the rdxp modules other than rdxp_ram.
// No dependencies.
`default_nettype none
package rdxp_pkg;

	localparam int PART_W     = 8;
	localparam int NPART      = 1 << PART_W;
	localparam int LINE_N     = 8;
	localparam int SLOT_W     = $clog2(LINE_N);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int KEY_W      = 64;
	localparam int PAGE_W     = 16;
	localparam int OFF_W      = 18;
	localparam int OFFW_W     = OFF_W - SLOT_W;
	localparam int PCNT_W     = PAGE_W + 1;
	localparam int PB_W       = 4;
	localparam int PB_MAX     = PART_W;
	localparam logic [PB_W-1:0] PB_RESET = PB_W'(4);
	localparam int LB_DEPTH   = NPART * LINE_N;
	localparam int LB_AW      = PART_W + SLOT_W;
	localparam int JOBQ_DEPTH = 2;
	localparam int JQ_AW      = $clog2(JOBQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
	localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

	localparam logic REQ_KEY    = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_SUM   = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LINE_N - 1);

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  key;
		logic [PART_W-1:0] flush_partition;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [PART_W-1:0] partition;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset;
		logic [KEY_W-1:0]  value;
		logic [PCNT_W-1:0] page_count;
		logic              overflow;
		logic              last;
	} rsp_t;

	// per-partition counters; the in-page offset is kept in line units
	typedef struct packed {
		logic              ovf;
		logic [PAGE_W-1:0] page;
		logic [OFFW_W-1:0] offw;
		logic [SLOT_W-1:0] slot;
	} pst_t;

	typedef struct packed {
		logic              flush;
		logic [PART_W-1:0] partition;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset_base;
		logic [CNT_W-1:0]  count;
		logic              overflow;
		logic [KEY_W-1:0]  key;
	} job_t;

	typedef struct packed {
		logic              busy;
		logic [PART_W-1:0] partition;
	} back_stat_t;

	// bucket = top bits of the key, bit count clamped to 1..PB_MAX
	function automatic logic [PART_W-1:0] key_part(input logic [KEY_W-1:0] key,
			input logic [PB_W-1:0] pb);
		logic [PB_W-1:0] b;
		logic [PB_W-1:0] sh;
		b = pb;
		if (b == '0) b = PB_W'(1);
		if (b > PB_W'(PB_MAX)) b = PB_W'(PB_MAX);
		sh = PB_W'(PB_MAX) - b;
		return key[KEY_W-1 -: PART_W] >> sh;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rdxp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rdxp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/rdxp_front.sv
// Front end: accepts requests, looks up and updates the partition counters,
// writes keys into the line buffer and hands line/flush jobs to the queue.
// Depends on rdxp_pkg and rdxp_ram.
`default_nettype none
module rdxp_front import rdxp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire req_t                req,
	input  wire logic [PB_W-1:0]     pbits,
	output logic                     lb_we,
	output logic      [LB_AW-1:0]    lb_waddr,
	output logic      [KEY_W-1:0]    lb_wdata,
	output logic                     job_push,
	output job_t                     job,
	input  wire logic                jobq_full,
	output logic      [PART_W-1:0]   chk_part,
	input  wire logic                chk_hit
);

	logic              s1_v_q;
	logic              s1_type_q;
	logic [KEY_W-1:0]  s1_key_q;
	logic [PART_W-1:0] s1_p_q;
	logic [NPART-1:0]  vld_q;
	logic              vld_rd_s1;
	logic              fwd_v_q;
	logic [PART_W-1:0] fwd_p_q;
	pst_t              fwd_st_q;
	logic [PART_W-1:0] in_p;
	logic [PART_W-1:0] rd_addr;
	logic [$bits(pst_t)-1:0] ram_rd;
	pst_t              st;
	pst_t              st_nxt;
	logic              need_lw;
	logic              s1_go;
	logic              accept;
	logic [OFFW_W:0]   offw_inc;

	assign in_p = (req.req_type == REQ_FLUSH) ? req.flush_partition : key_part(req.key, pbits);

	// last write bypasses the RAM for the item right behind it
	always_comb begin
		if (fwd_v_q && fwd_p_q == s1_p_q) st = fwd_st_q;
		else if (vld_rd_s1) st = pst_t'(ram_rd);
		else st = '0;
	end

	assign need_lw  = (s1_type_q == REQ_KEY) && (st.slot != SLOT_LAST);
	// a key may not land in a line that is still being drained
	assign s1_go    = s1_v_q && !(need_lw && chk_hit) && !(!need_lw && jobq_full);
	assign full     = s1_v_q && !s1_go;
	assign accept   = push && !full;
	assign rd_addr  = full ? s1_p_q : in_p;
	assign chk_part = s1_p_q;

	assign offw_inc = {1'b0, st.offw} + (OFFW_W+1)'(1);

	always_comb begin
		st_nxt = st;
		if (s1_type_q == REQ_FLUSH) begin
			st_nxt = '0;
		end else if (need_lw) begin
			st_nxt.slot = st.slot + SLOT_W'(1);
		end else begin
			st_nxt.slot = '0;
			st_nxt.offw = offw_inc[OFFW_W-1:0];
			if (offw_inc[OFFW_W]) begin
				if (&st.page) st_nxt.ovf = 1'b1;
				else st_nxt.page = st.page + PAGE_W'(1);
			end
		end
	end

	always_comb begin
		job.flush       = (s1_type_q == REQ_FLUSH);
		job.partition   = s1_p_q;
		job.page        = st.page;
		job.offset_base = {st.offw, {SLOT_W{1'b0}}};
		job.count       = (s1_type_q == REQ_FLUSH) ? {1'b0, st.slot} : CNT_W'(LINE_N);
		job.overflow    = st.ovf;
		job.key         = s1_key_q;
	end

	assign job_push = s1_go && !need_lw;
	assign lb_we    = s1_go && need_lw;
	assign lb_waddr = {s1_p_q, st.slot};
	assign lb_wdata = s1_key_q;

	rdxp_ram #(.WIDTH($bits(pst_t)), .DEPTH(NPART)) u_st_ram (
		.clk   (clk),
		.we    (s1_go),
		.waddr (s1_p_q),
		.wdata (st_nxt),
		.raddr (rd_addr),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q    <= 1'b0;
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
			fwd_v_q   <= 1'b0;
		end else begin
			vld_rd_s1 <= vld_q[rd_addr];
			if (accept) s1_v_q <= 1'b1;
			else if (s1_go) s1_v_q <= 1'b0;
			if (s1_go) begin
				vld_q[s1_p_q] <= 1'b1;
				fwd_v_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_type_q <= req.req_type;
			s1_key_q  <= req.key;
			s1_p_q    <= in_p;
		end
		if (s1_go) begin
			fwd_p_q  <= s1_p_q;
			fwd_st_q <= st_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rdxp_jobq.sv
// Short job queue between front and back end; also reports whether a
// queued job touches a given partition.
// Depends on rdxp_pkg.
`default_nettype none
module rdxp_jobq import rdxp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire job_t              din,
	output logic                   full,
	input  wire logic              pop,
	output job_t                   dout,
	output logic                   empty,
	input  wire logic [PART_W-1:0] chk_part,
	output logic                   hit
);

	job_t                  mem_q [JOBQ_DEPTH];
	logic [JOBQ_DEPTH-1:0] vld_q;
	logic [JQ_AW-1:0]      wp_q;
	logic [JQ_AW-1:0]      rp_q;

	assign full  = vld_q[wp_q];
	assign empty = !vld_q[rp_q];
	assign dout  = mem_q[rp_q];

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < JOBQ_DEPTH; i++)
			if (vld_q[i] && mem_q[i].partition == chk_part) hit = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
		end else begin
			if (push && !full) begin
				vld_q[wp_q] <= 1'b1;
				wp_q        <= wp_q + JQ_AW'(1);
			end
			if (pop && !empty) begin
				vld_q[rp_q] <= 1'b0;
				rp_q        <= rp_q + JQ_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

endmodule
`default_nettype wire

FILE: rtl/core/rdxp_back.sv
// Back end: walks a job entry by entry, reads the line buffer and queues
// entry writes and summaries in a small result queue.
// Depends on rdxp_pkg.
`default_nettype none
module rdxp_back import rdxp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             jq_empty,
	output logic                  jq_pop,
	input  wire job_t             job,
	output logic      [LB_AW-1:0] lb_raddr,
	input  wire logic [KEY_W-1:0] lb_rdata,
	output back_stat_t            stat,
	output logic                  empty,
	input  wire logic             pop,
	output rsp_t                  rsp
);

	job_t             job_q;
	logic             active_q;
	logic [CNT_W-1:0] j_q;
	logic             pv_s1;
	rsp_t             pr_s1;
	logic             use_ram_s1;
	rsp_t             oq_q [OUTQ_DEPTH];
	logic [OQ_AW-1:0] owp_q;
	logic [OQ_AW-1:0] orp_q;
	logic [OQ_CW-1:0] oc_q;
	logic [OQ_CW-1:0] occ_tot;
	logic             load;
	logic             is_sum;
	logic             is_keyslot;
	logic             fin;
	logic             step;
	logic             opop;
	rsp_t             res;

	assign load       = !active_q && !jq_empty;
	assign jq_pop     = load;
	assign is_sum     = job_q.flush && (j_q == job_q.count);
	// the key that completed the line never went through the buffer
	assign is_keyslot = !job_q.flush && (j_q == CNT_W'(LINE_N - 1));
	assign fin        = is_sum || is_keyslot;
	// count the read in flight so the result queue can never overrun
	assign occ_tot    = oc_q + OQ_CW'(pv_s1);
	assign step       = active_q && (occ_tot < OQ_CW'(OUTQ_DEPTH));
	assign lb_raddr   = {job_q.partition, j_q[SLOT_W-1:0]};
	assign stat.busy      = active_q;
	assign stat.partition = job_q.partition;

	always_comb begin
		res = pr_s1;
		if (use_ram_s1) res.value = lb_rdata;
	end

	assign opop  = pop && !empty;
	assign empty = (oc_q == '0);
	assign rsp   = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			j_q      <= '0;
			pv_s1    <= 1'b0;
			owp_q    <= '0;
			orp_q    <= '0;
			oc_q     <= '0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				j_q      <= '0;
			end else if (step) begin
				if (fin) active_q <= 1'b0;
				j_q <= j_q + CNT_W'(1);
			end
			pv_s1 <= step;
			if (pv_s1) owp_q <= owp_q + OQ_AW'(1);
			if (opop) orp_q <= orp_q + OQ_AW'(1);
			oc_q <= oc_q + OQ_CW'(pv_s1) - OQ_CW'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (load) job_q <= job;
		if (step) begin
			pr_s1.kind       <= is_sum ? KIND_SUM : KIND_WRITE;
			pr_s1.partition  <= job_q.partition;
			pr_s1.page       <= job_q.page;
			pr_s1.offset     <= job_q.offset_base + OFF_W'(j_q);
			pr_s1.value      <= is_keyslot ? job_q.key : '0;
			pr_s1.page_count <= is_sum ? ({1'b0, job_q.page} + PCNT_W'(1)) : '0;
			pr_s1.overflow   <= job_q.overflow;
			pr_s1.last       <= fin;
			use_ram_s1       <= !is_sum && !is_keyslot;
		end
		if (pv_s1) oq_q[owp_q] <= res;
	end

endmodule
`default_nettype wire

FILE: rtl/core/radix_partitioner_write_combine.sv
// Radix partitioner with per-partition write-combining line buffers.
// Top level: config register, line buffer RAM, front end, job queue, back end.
// Depends on rdxp_pkg, rdxp_ram, rdxp_front, rdxp_jobq, rdxp_back.
//
// Usage:
//   Requests enter through push/full as req_t items: a key to partition, or a
//   flush of one partition. Results leave through empty/pop as rsp_t items;
//   the oldest is on rsp while empty is low. partition_bits is written over
//   cfg_valid/cfg_ready/cfg_data (ready is always high) while the block idles.
// Timing:
//   A key that only fills a line slot goes into the line buffer; keys stream
//   at one per cycle unless the front end stalls. A key that completes a
//   line, or a flush, becomes a job that passes the job queue and the back
//   end read stage into the result queue; its results follow at one per
//   cycle while that queue has room (8 for a line, slots plus summary for a
//   flush), set by the single line buffer read port. A key to a partition
//   whose line is still queued or draining waits for that drain.
// Reset:
//   arst_n clears all counters at once (per-partition valid bits, no clearing
//   pass) and sets partition_bits to 4. When pop stays low the result queue
//   fills, the back end stops, the job queue fills and full rises.
`default_nettype none
module radix_partitioner_write_combine import rdxp_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire req_t            req,
	output logic                 empty,
	input  wire logic            pop,
	output rsp_t                 rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [PB_W-1:0] cfg_data
);

	logic [PB_W-1:0]   pbits_q;
	logic              lb_we;
	logic [LB_AW-1:0]  lb_waddr;
	logic [KEY_W-1:0]  lb_wdata;
	logic [LB_AW-1:0]  lb_raddr;
	logic [KEY_W-1:0]  lb_rdata;
	logic              job_push;
	job_t              job_in;
	job_t              job_out;
	logic              jq_full;
	logic              jq_empty;
	logic              jq_pop;
	logic [PART_W-1:0] chk_part;
	logic              jq_hit;
	logic              chk_hit;
	back_stat_t        bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pbits_q <= PB_RESET;
		else if (cfg_valid && cfg_ready) pbits_q <= cfg_data;
	end

	assign chk_hit = jq_hit || (bstat.busy && bstat.partition == chk_part);

	rdxp_ram #(.WIDTH(KEY_W), .DEPTH(LB_DEPTH)) u_lb_ram (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_waddr),
		.wdata (lb_wdata),
		.raddr (lb_raddr),
		.rdata (lb_rdata)
	);

	rdxp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.pbits     (pbits_q),
		.lb_we     (lb_we),
		.lb_waddr  (lb_waddr),
		.lb_wdata  (lb_wdata),
		.job_push  (job_push),
		.job       (job_in),
		.jobq_full (jq_full),
		.chk_part  (chk_part),
		.chk_hit   (chk_hit)
	);

	rdxp_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.din      (job_in),
		.full     (jq_full),
		.pop      (jq_pop),
		.dout     (job_out),
		.empty    (jq_empty),
		.chk_part (chk_part),
		.hit      (jq_hit)
	);

	rdxp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.jq_empty (jq_empty),
		.jq_pop   (jq_pop),
		.job      (job_out),
		.lb_raddr (lb_raddr),
		.lb_rdata (lb_rdata),
		.stat     (bstat),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

	a_jobq_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && jq_full))
		else $error("job pushed into full job queue");

	a_no_write_to_draining_line: assert property (@(posedge clk) disable iff (!arst_n)
		lb_we |-> !(bstat.busy && bstat.partition == lb_waddr[LB_AW-1 -: PART_W]))
		else $error("line buffer write to partition being drained");

	a_summary_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.kind == KIND_SUM) |-> rsp.last)
		else $error("summary result not marked last");

	a_job_taken_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |=> bstat.busy)
		else $error("back end did not start a dequeued job");

endmodule
`default_nettype wire

FILE: tb/tb_radix_partitioner_write_combine.sv
// Testbench for radix_partitioner_write_combine: streams keys and flushes,
// predicts every entry write and partition summary and checks them in order.
// Depends on rdxp_pkg and the block's RTL.
module tb_radix_partitioner_write_combine;
	import rdxp_pkg::*;

	localparam int PAGE_SLOTS    = 262144;
	localparam int PAGE_LAST     = 65535;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX    = 40;

	class partition_scoreboard;
		logic [KEY_W-1:0] line_keys [NPART][LINE_N];
		int unsigned      slots [NPART];
		int unsigned      offs [NPART];
		int unsigned      pages [NPART];
		bit               ovf [NPART];
		int unsigned      pbits;
		rsp_t             pending [$];
		int               errors;
		int               reported;

		function new();
			for (int i = 0; i < NPART; i++) begin
				slots[i] = 0;
				offs[i]  = 0;
				pages[i] = 0;
				ovf[i]   = 1'b0;
			end
			pbits    = 32'(PB_RESET);
			errors   = 0;
			reported = 0;
		endfunction

		function void set_bits(logic [PB_W-1:0] v);
			pbits = 32'(v);
		endfunction

		function void queue_write(int unsigned p, int unsigned j, bit is_last);
			rsp_t r;
			r = '0;
			r.kind      = KIND_WRITE;
			r.partition = PART_W'(p);
			r.page      = PAGE_W'(pages[p]);
			r.offset    = OFF_W'(offs[p] + j);
			r.value     = line_keys[p][j];
			r.overflow  = ovf[p];
			r.last      = is_last;
			pending.push_back(r);
		endfunction

		function void note_req(req_t q);
			int unsigned b;
			int unsigned p;
			rsp_t r;
			if (q.req_type == REQ_KEY) begin
				b = pbits;
				if (b < 1) b = 1;
				if (b > PB_MAX) b = PB_MAX;
				p = 32'((q.key >> (KEY_W - b)) % NPART);
				line_keys[p][slots[p]] = q.key;
				if (slots[p] < LINE_N - 1) begin
					slots[p]++;
					return;
				end
				for (int unsigned j = 0; j < LINE_N; j++)
					queue_write(p, j, j == LINE_N - 1);
				offs[p] += LINE_N;
				// page wraps; the index sticks at the top page and marks overflow
				if (offs[p] >= PAGE_SLOTS) begin
					offs[p] = 0;
					if (pages[p] == PAGE_LAST)
						ovf[p] = 1'b1;
					else
						pages[p]++;
				end
				slots[p] = 0;
			end else begin
				p = 32'(q.flush_partition);
				for (int unsigned j = 0; j < slots[p]; j++)
					queue_write(p, j, 1'b0);
				r = '0;
				r.kind       = KIND_SUM;
				r.partition  = PART_W'(p);
				r.page       = PAGE_W'(pages[p]);
				r.offset     = OFF_W'(offs[p] + slots[p]);
				r.page_count = PCNT_W'(pages[p] + 1);
				r.overflow   = ovf[p];
				r.last       = 1'b1;
				pending.push_back(r);
				slots[p] = 0;
				offs[p]  = 0;
				pages[p] = 0;
				ovf[p]   = 1'b0;
			end
		endfunction

		function bit field_matches(string name, logic [63:0] want_v, logic [63:0] got_v);
			if (got_v === want_v) return 1'b1;
			if (reported < REPORT_MAX)
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
					want_v, got_v);
			reported++;
			return 1'b0;
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			bit ok;
			if (pending.size() == 0) begin
				if (reported < REPORT_MAX)
					$display("%0t: unexpected item: expected none, actual partition %0h value %0h",
						$time, got.partition, got.value);
				reported++;
				errors++;
				return;
			end
			want = pending.pop_front();
			ok = 1'b1;
			ok &= field_matches("kind", 64'(want.kind), 64'(got.kind));
			ok &= field_matches("partition", 64'(want.partition), 64'(got.partition));
			ok &= field_matches("page", 64'(want.page), 64'(got.page));
			ok &= field_matches("offset", 64'(want.offset), 64'(got.offset));
			ok &= field_matches("value", want.value, got.value);
			ok &= field_matches("page_count", 64'(want.page_count), 64'(got.page_count));
			ok &= field_matches("overflow", 64'(want.overflow), 64'(got.overflow));
			ok &= field_matches("last", 64'(want.last), 64'(got.last));
			if (!ok) errors++;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	req_t             req;
	logic             empty;
	logic             pop;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [PB_W-1:0]  cfg_data;

	partition_scoreboard sb;
	int               idle_pct   = 0;
	int               stall_pct  = 0;
	bit               hold_start = 1'b0;
	int unsigned      eff_bits   = 32'(PB_RESET);

	radix_partitioner_write_combine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) sb.note_req(req);
		if (arst_n && pop && !empty) sb.check_rsp(rsp);
	end

	// result side; a long hold-off lets the block back up into full
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_left  = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [KEY_W-1:0] key_for(int unsigned part);
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		k[KEY_W-1 -: PART_W] = PART_W'((part << (PART_W - eff_bits))
			| ($urandom & ((1 << (PART_W - eff_bits)) - 1)));
		return k;
	endfunction

	function automatic req_t key_req(logic [KEY_W-1:0] k);
		req_t r;
		r.req_type        = REQ_KEY;
		r.key             = k;
		r.flush_partition = PART_W'($urandom);
		return r;
	endfunction

	function automatic req_t flush_req(logic [PART_W-1:0] p);
		req_t r;
		r.req_type        = REQ_FLUSH;
		r.key             = {$urandom, $urandom};
		r.flush_partition = p;
		return r;
	endfunction

	// called at a falling edge; returns at a falling edge after the item is taken
	task automatic send(req_t r);
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
	endtask

	// drain everything expected; keys that only fill slots give no result
	task automatic settle();
		push <= 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_bits(logic [PB_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_bits(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
		eff_bits = (v == 0) ? 1 : (v > PB_MAX) ? PB_MAX : 32'(v);
	endtask

	task automatic random_phase(int n, int idle_p, int stall_p, bit squeeze);
		int unsigned hot [3];
		int unsigned span;
		int unsigned p;
		span = 1 << eff_bits;
		for (int h = 0; h < 3; h++) hot[h] = $urandom_range(span - 1);
		idle_pct  = idle_p;
		stall_pct = stall_p;
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == 5) hold_start = 1'b1;
			if ($urandom_range(99) < 10) begin
				p = $urandom_range(1) ? hot[$urandom_range(2)] : $urandom_range(NPART - 1);
				send(flush_req(PART_W'(p)));
			end else begin
				p = ($urandom_range(99) < 80) ? hot[$urandom_range(2)]
					: $urandom_range(span - 1);
				send(key_req(key_for(p)));
			end
		end
		settle();
	endtask

	initial begin : main
		sb = new();
		arst_n    = 1'b0;
		push      = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, partition_bits still at reset (16 partitions)
		send(key_req('0));
		send(key_req('1));
		repeat (6) send(key_req(key_for(0)));
		send(key_req(64'h0FFF_FFFF_FFFF_FFFF));
		send(flush_req(8'd15));   // one partial entry, then summary
		send(flush_req(8'd3));    // never used: summary only
		send(flush_req(8'hFF));   // above the configured partition count
		send(flush_req(8'd0));    // line already written out, summary only at offset 8
		send(flush_req(8'd0));    // freshly cleared
		settle();

		write_bits(4'd1);
		random_phase(50, 0, 0, 1'b0);
		write_bits(PB_W'(PB_MAX));
		random_phase(50, 68, 0, 1'b0);
		write_bits(4'd0);
		random_phase(50, 0, 68, 1'b0);
		write_bits(4'hF);
		random_phase(50, 14, 14, 1'b0);
		write_bits(PB_W'($urandom_range(7, 2)));
		random_phase(55, 0, 0, 1'b1);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
